// ===== src/aabb_pkg.sv =====
// aabb_pkg: shared types, codes and sizes for the collider pair table.
// No dependencies; imported by every module in src.
`timescale 1ns / 1ps

package aabb_pkg;

  localparam int SlotsDef   = 16;  // default table depth
  localparam int MaxResults = 16;  // results per check, final included
  localparam int SlotW      = 4;   // slot field width on the ports
  localparam int KindW      = 4;
  localparam int MaskRegs   = 4;
  localparam int MaskW      = 64;
  localparam int CntW       = $clog2(MaxResults);

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_UPDATE = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_CHECK  = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [14:0]        h;
    logic [14:0]        w;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } rect_t;

  typedef struct packed {
    logic             handler;
    logic [KindW-1:0] code;
  } kind_t;

  // write enables of the two store arrays
  typedef struct packed {
    logic rect;
    logic kind;
  } store_we_t;

  // outcome of one pair comparison
  typedef struct packed {
    logic overlap;
    logic nf;
    logic ns;
  } ovl_res_t;

endpackage

// ===== src/aabb_collision_pair_table.sv =====
// aabb_collision_pair_table: top level, command sequencer, slot valid bits, mask registers.
// Depends on aabb_pkg, aabb_store and aabb_overlap.
`timescale 1ns / 1ps

// Channel  | Ports                                            | Handshake
// ---------+--------------------------------------------------+-------------------------------
// command  | command_i slot_i rect_x_i rect_y_i rect_w_i      | taken when start_i && !busy_o
//          | rect_h_i kind_i has_handler_i                    |
// result   | status_o first_slot_o second_slot_o hit_o        | one cycle, result_strobe_o
//          | notify_first_o notify_second_o last_o            |
// config   | cfg_we_i cfg_index_i cfg_wdata_i                 | written when cfg_we_i
//
// Update, remove, clear and rejected commands: the result shows in the cycle
// after the item is taken and busy_o stays low.
// Add walks the valid bits from slot 0, one a cycle, and gives its result at the
// lowest free slot, or status ST_FULL once the last slot is found taken.
// Check of slot i: slot i is fetched from the single read port, then one
// stored slot compared per cycle for k = i+1 .. SLOTS-1 (or until the hit budget
// is spent), then the final item. Hits appear while the walk runs.
// Reset clears the valid bits and mask registers at once; the stores need none.
// The receiver cannot stall: every result item is taken in its one cycle.

module aabb_collision_pair_table
  import aabb_pkg::*;
#(
  parameter int SLOTS = SlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [2:0]          command_i,
  input  logic [SlotW-1:0]    slot_i,
  input  logic signed [15:0]  rect_x_i,
  input  logic signed [15:0]  rect_y_i,
  input  logic [14:0]         rect_w_i,
  input  logic [14:0]         rect_h_i,
  input  logic [KindW-1:0]    kind_i,
  input  logic                has_handler_i,
  output logic                result_strobe_o,
  output logic [1:0]          status_o,
  output logic [SlotW-1:0]    first_slot_o,
  output logic [SlotW-1:0]    second_slot_o,
  output logic                hit_o,
  output logic                notify_first_o,
  output logic                notify_second_o,
  output logic                last_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [MaskW-1:0]    cfg_wdata_i
);

  localparam int IdxW = $clog2(SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);
  localparam logic [CntW-1:0] CapM1   = CntW'(MaxResults - 2);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIND  = 3'd1;  // add: search for a free slot
  localparam logic [2:0] S_BASE  = 3'd2;  // check: checked slot arriving from store
  localparam logic [2:0] S_WALK  = 3'd3;  // check: one candidate per cycle
  localparam logic [2:0] S_FINAL = 3'd4;  // check: closing item

  logic [2:0]                   state_q, state_d;
  logic [SLOTS-1:0]             occ_q, occ_d;
  logic [MaskRegs-1:0][MaskW-1:0] mask_q;
  logic [IdxW-1:0]              kp_q, kp_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [IdxW-1:0]              base_slot_q, base_slot_d;
  rect_t                        base_rect_q, base_rect_d;
  kind_t                        base_kind_q, base_kind_d;
  rect_t                        new_rect_q, new_rect_d;
  kind_t                        new_kind_q, new_kind_d;

  logic                         strobe_q, strobe_d;
  logic [1:0]                   status_q, status_d;
  logic [SlotW-1:0]             first_q, first_d;
  logic [SlotW-1:0]             second_q, second_d;
  logic                         hit_q, hit_d;
  logic                         nf_q, nf_d;
  logic                         ns_q, ns_d;
  logic                         last_q, last_d;

  logic                         accept;
  logic [IdxW-1:0]              slot_idx;
  logic                         slot_ok;
  rect_t                        in_rect;
  store_we_t                    st_we;
  logic [IdxW-1:0]              st_wr_addr;
  rect_t                        st_wr_rect;
  kind_t                        st_wr_kind;
  logic [IdxW-1:0]              st_rd_addr;
  rect_t                        rd_rect;
  kind_t                        rd_kind;
  ovl_res_t                     ovl;
  logic                         pair_hit;

  // next slot after a, wrapped to 0 past the end (that read is never used)
  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] a);
    logic [IdxW:0] n;
    n = {1'b0, a} + 1'b1;
    return (n < SLOTS) ? n[IdxW-1:0] : '0;
  endfunction

  assign accept   = start_i && !busy_o;
  assign slot_idx = IdxW'(slot_i);
  assign slot_ok  = (slot_i < SLOTS) && occ_q[slot_idx];
  assign in_rect  = '{h: rect_h_i, w: rect_w_i, y: rect_y_i, x: rect_x_i};
  assign pair_hit = occ_q[kp_q] && ovl.overlap;

  aabb_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .wr_addr_i (st_wr_addr),
    .wr_rect_i (st_wr_rect),
    .wr_kind_i (st_wr_kind),
    .rd_addr_i (st_rd_addr),
    .rd_rect_o (rd_rect),
    .rd_kind_o (rd_kind)
  );

  aabb_overlap u_overlap (
    .base_rect_i (base_rect_q),
    .base_kind_i (base_kind_q),
    .cand_rect_i (rd_rect),
    .cand_kind_i (rd_kind),
    .mask_i      (mask_q),
    .res_o       (ovl)
  );

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    kp_d        = kp_q;
    cnt_d       = cnt_q;
    base_slot_d = base_slot_q;
    base_rect_d = base_rect_q;
    base_kind_d = base_kind_q;
    new_rect_d  = new_rect_q;
    new_kind_d  = new_kind_q;

    strobe_d = 1'b0;
    status_d = ST_OK;
    first_d  = '0;
    second_d = '0;
    hit_d    = 1'b0;
    nf_d     = 1'b0;
    ns_d     = 1'b0;
    last_d   = 1'b0;

    st_we      = '0;
    st_wr_addr = kp_q;
    st_wr_rect = new_rect_q;
    st_wr_kind = new_kind_q;
    st_rd_addr = slot_idx;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_ADD: begin
              new_rect_d = in_rect;
              new_kind_d = '{handler: has_handler_i, code: kind_i};
              kp_d       = '0;
              state_d    = S_FIND;
            end
            CMD_UPDATE: begin
              strobe_d = 1'b1;
              last_d   = 1'b1;
              first_d  = slot_i;
              if (slot_ok) begin
                st_we.rect = 1'b1;
                st_wr_addr = slot_idx;
                st_wr_rect = in_rect;
              end else begin
                status_d = ST_EMPTY;
              end
            end
            CMD_REMOVE: begin
              strobe_d = 1'b1;
              last_d   = 1'b1;
              first_d  = slot_i;
              if (slot_ok) begin
                occ_d[slot_idx] = 1'b0;
              end else begin
                status_d = ST_EMPTY;
              end
            end
            CMD_CHECK: begin
              if (slot_ok) begin
                // store read of the checked slot is issued on this edge
                base_slot_d = slot_idx;
                state_d     = S_BASE;
              end else begin
                strobe_d = 1'b1;
                last_d   = 1'b1;
                first_d  = slot_i;
                status_d = ST_EMPTY;
              end
            end
            CMD_CLEAR: begin
              occ_d    = '0;
              strobe_d = 1'b1;
              last_d   = 1'b1;
            end
            default: begin
              // unused codes: taken, no result
            end
          endcase
        end
      end

      S_FIND: begin
        if (!occ_q[kp_q]) begin
          occ_d[kp_q] = 1'b1;
          st_we       = '{rect: 1'b1, kind: 1'b1};
          strobe_d    = 1'b1;
          last_d      = 1'b1;
          first_d     = SlotW'(kp_q);
          state_d     = S_IDLE;
        end else if (kp_q == LastIdx) begin
          strobe_d = 1'b1;
          last_d   = 1'b1;
          status_d = ST_FULL;
          state_d  = S_IDLE;
        end else begin
          kp_d = kp_q + 1'b1;
        end
      end

      S_BASE: begin
        st_rd_addr  = next_idx(base_slot_q);
        base_rect_d = rd_rect;
        base_kind_d = rd_kind;
        kp_d        = next_idx(base_slot_q);
        cnt_d       = '0;
        state_d     = (base_slot_q == LastIdx) ? S_FINAL : S_WALK;
      end

      S_WALK: begin
        // read data belongs to slot kp_q; next address goes out meanwhile
        st_rd_addr = next_idx(kp_q);
        kp_d       = next_idx(kp_q);
        if (pair_hit) begin
          strobe_d = 1'b1;
          hit_d    = 1'b1;
          first_d  = SlotW'(base_slot_q);
          second_d = SlotW'(kp_q);
          nf_d     = ovl.nf;
          ns_d     = ovl.ns;
          cnt_d    = cnt_q + 1'b1;
        end
        // stop at the table end, or once the hit budget is spent
        if ((kp_q == LastIdx) || (pair_hit && (cnt_q == CapM1))) begin
          state_d = S_FINAL;
        end
      end

      S_FINAL: begin
        strobe_d = 1'b1;
        last_d   = 1'b1;
        first_d  = SlotW'(base_slot_q);
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      occ_q    <= '0;
      mask_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      strobe_q <= strobe_d;
      if (cfg_we_i) begin
        mask_q[cfg_index_i] <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kp_q        <= kp_d;
    cnt_q       <= cnt_d;
    base_slot_q <= base_slot_d;
    base_rect_q <= base_rect_d;
    base_kind_q <= base_kind_d;
    new_rect_q  <= new_rect_d;
    new_kind_q  <= new_kind_d;
    status_q    <= status_d;
    first_q     <= first_d;
    second_q    <= second_d;
    hit_q       <= hit_d;
    nf_q        <= nf_d;
    ns_q        <= ns_d;
    last_q      <= last_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign result_strobe_o = strobe_q;
  assign status_o        = status_q;
  assign first_slot_o    = first_q;
  assign second_slot_o   = second_q;
  assign hit_o           = hit_q;
  assign notify_first_o  = nf_q;
  assign notify_second_o = ns_q;
  assign last_o          = last_q;

  // a busy spell always closes with the command's final item
  a_busy_end_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_strobe_o && last_o)
    else $error("busy ended without a final item");

  // a hit item is never the last one and always carries ok status
  a_hit_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && hit_o |-> !last_o && (status_o == ST_OK))
    else $error("hit item marked last or with error status");

  // every non-hit item ends its command and has clear pair fields
  a_nonhit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !hit_o |-> last_o && !notify_first_o && !notify_second_o
      && (second_slot_o == '0))
    else $error("non-hit item with stray pair fields");

  // hits only come out while a check walk is running
  a_hit_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && hit_o |-> $past(state_q == S_WALK))
    else $error("hit item outside a check walk");

endmodule

// ===== src/aabb_store.sv =====
// aabb_store: rectangle and kind arrays, one write and one registered read port.
// Depends on aabb_pkg.
`timescale 1ns / 1ps

module aabb_store
  import aabb_pkg::*;
#(
  parameter int SLOTS = SlotsDef
) (
  input  logic                     clk_i,
  input  store_we_t                we_i,
  input  logic [$clog2(SLOTS)-1:0] wr_addr_i,
  input  rect_t                    wr_rect_i,
  input  kind_t                    wr_kind_i,
  input  logic [$clog2(SLOTS)-1:0] rd_addr_i,
  output rect_t                    rd_rect_o,
  output kind_t                    rd_kind_o
);

  rect_t mem_rect [SLOTS];
  kind_t mem_kind [SLOTS];
  rect_t rd_rect_q;
  kind_t rd_kind_q;

  always_ff @(posedge clk_i) begin
    if (we_i.rect) begin
      mem_rect[wr_addr_i] <= wr_rect_i;
    end
    if (we_i.kind) begin
      mem_kind[wr_addr_i] <= wr_kind_i;
    end
    rd_rect_q <= mem_rect[rd_addr_i];
    rd_kind_q <= mem_kind[rd_addr_i];
  end

  assign rd_rect_o = rd_rect_q;
  assign rd_kind_o = rd_kind_q;

endmodule

// ===== src/aabb_overlap.sv =====
// aabb_overlap: shared pair compare unit, inclusive box overlap plus notify mask lookup.
// Depends on aabb_pkg.
`timescale 1ns / 1ps

module aabb_overlap
  import aabb_pkg::*;
(
  input  rect_t                        base_rect_i,
  input  kind_t                        base_kind_i,
  input  rect_t                        cand_rect_i,
  input  kind_t                        cand_kind_i,
  input  logic [MaskRegs*MaskW-1:0]    mask_i,
  output ovl_res_t                     res_o
);

  logic signed [16:0] bx, by, bx2, by2, cx, cy, cx2, cy2;
  logic               sep;

  always_comb begin
    bx  = {base_rect_i.x[15], base_rect_i.x};
    by  = {base_rect_i.y[15], base_rect_i.y};
    cx  = {cand_rect_i.x[15], cand_rect_i.x};
    cy  = {cand_rect_i.y[15], cand_rect_i.y};
    bx2 = bx + $signed({2'b00, base_rect_i.w});
    by2 = by + $signed({2'b00, base_rect_i.h});
    cx2 = cx + $signed({2'b00, cand_rect_i.w});
    cy2 = cy + $signed({2'b00, cand_rect_i.h});
    // touching edges count as overlap
    sep = (cx > bx2) || (cx2 < bx) || (cy > by2) || (cy2 < by);
    res_o.overlap = !sep;
    // flat mask index is {row kind, column kind}
    res_o.nf = mask_i[{base_kind_i.code, cand_kind_i.code}] & base_kind_i.handler;
    res_o.ns = mask_i[{cand_kind_i.code, base_kind_i.code}] & cand_kind_i.handler;
  end

endmodule

// ===== tb/aabb_collision_pair_table_tb.sv =====
// aabb_collision_pair_table_tb: self-checking bench for the collider pair table.
// Depends on aabb_pkg and aabb_collision_pair_table; scripted items, then random phases.
`timescale 1ns / 1ps

module aabb_collision_pair_table_tb;
  import aabb_pkg::*;

  localparam int SLOTS  = SlotsDef;
  localparam int SETTLE = SLOTS + 4;     // longest walk plus margin, in cycles
  localparam int PHASE_ITEMS = 56;

  // commands the block ignores: no result item
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam logic [1:0] REG_MASK_0 = 2'd0;
  localparam logic [1:0] REG_MASK_1 = 2'd1;
  localparam logic [1:0] REG_MASK_2 = 2'd2;
  localparam logic [1:0] REG_MASK_3 = 2'd3;

  // one result item as seen on the ports
  typedef struct packed {
    logic [1:0]       status;
    logic [SlotW-1:0] first;
    logic [SlotW-1:0] second;
    logic             hit;
    logic             nf;
    logic             ns;
    logic             last;
  } pair_report_t;

  // one line of the scripted opening; typed rows carry their single result
  typedef struct packed {
    logic [2:0]         cmd;
    logic [SlotW-1:0]   slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic [KindW-1:0]   kind;
    logic               handler;
    int                 reps;
    bit                 typed;
    pair_report_t       want;
  } script_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [2:0]         command_i;
  logic [SlotW-1:0]   slot_i;
  logic signed [15:0] rect_x_i;
  logic signed [15:0] rect_y_i;
  logic [14:0]        rect_w_i;
  logic [14:0]        rect_h_i;
  logic [KindW-1:0]   kind_i;
  logic               has_handler_i;
  logic               result_strobe_o;
  logic [1:0]         status_o;
  logic [SlotW-1:0]   first_slot_o;
  logic [SlotW-1:0]   second_slot_o;
  logic               hit_o;
  logic               notify_first_o;
  logic               notify_second_o;
  logic               last_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [MaskW-1:0]   cfg_wdata_i;

  aabb_collision_pair_table #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .slot_i          (slot_i),
    .rect_x_i        (rect_x_i),
    .rect_y_i        (rect_y_i),
    .rect_w_i        (rect_w_i),
    .rect_h_i        (rect_h_i),
    .kind_i          (kind_i),
    .has_handler_i   (has_handler_i),
    .result_strobe_o (result_strobe_o),
    .status_o        (status_o),
    .first_slot_o    (first_slot_o),
    .second_slot_o   (second_slot_o),
    .hit_o           (hit_o),
    .notify_first_o  (notify_first_o),
    .notify_second_o (notify_second_o),
    .last_o          (last_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the table. Updated in the sampling block at the edge that takes
  // an item or a register write, so it always matches what the block has seen.
  // The driver only reads it at falling edges, never at the sampling edge.
  // ---------------------------------------------------------------------------
  logic             slot_used [SLOTS] = '{default: 1'b0};
  rect_t            rect_mem  [SLOTS];
  kind_t            kind_mem  [SLOTS];
  logic [MaskW-1:0] mask_mem  [MaskRegs] = '{default: '0};

  pair_report_t reports_due [$];   // results owed by the block, oldest first
  int           mismatches = 0;

  // set by the driver with each item: use this result instead of the shadow's
  bit           typed_on;
  pair_report_t typed_want;

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // inclusive test: rectangles that only share an edge or corner still touch
  function automatic bit rects_touch(input rect_t p, input rect_t q);
    int px, py, pw, ph, qx, qy, qw, qh;
    px = int'(p.x);
    py = int'(p.y);
    pw = int'(p.w);
    ph = int'(p.h);
    qx = int'(q.x);
    qy = int'(q.y);
    qw = int'(q.w);
    qh = int'(q.h);
    return !(qx > px + pw || qx + qw < px || qy > py + ph || qy + qh < py);
  endfunction

  // mask entry for kind a against kind b: row a%4 of register a/4, column b
  function automatic logic mask_says(input logic [KindW-1:0] a, input logic [KindW-1:0] b);
    return mask_mem[a[3:2]][{a[1:0], b}];
  endfunction

  function automatic pair_report_t closing_report(input logic [1:0] status,
                                                  input logic [SlotW-1:0] first);
    pair_report_t r;
    r        = '0;
    r.status = status;
    r.first  = first;
    r.last   = 1'b1;
    return r;
  endfunction

  // Applies one command to the shadow and lists the results it gives.
  task automatic run_table_command(input logic [2:0] cmd, input logic [SlotW-1:0] slot,
                                   input rect_t r, input kind_t k,
                                   ref pair_report_t made [$]);
    pair_report_t hit_rep;
    bit           placed;
    int           hits;
    placed = 1'b0;
    hits   = 0;
    case (cmd)
      CMD_ADD: begin
        // lowest free slot wins; a full table changes nothing
        for (int i = 0; i < SLOTS; i++) begin
          if (!placed && !slot_used[i]) begin
            placed       = 1'b1;
            slot_used[i] = 1'b1;
            rect_mem[i]  = r;
            kind_mem[i]  = k;
            made.push_back(closing_report(ST_OK, SlotW'(i)));
          end
        end
        if (!placed) made.push_back(closing_report(ST_FULL, '0));
      end
      CMD_UPDATE, CMD_REMOVE, CMD_CHECK: begin
        if (!slot_used[slot]) begin
          made.push_back(closing_report(ST_EMPTY, slot));
        end else if (cmd == CMD_UPDATE) begin
          rect_mem[slot] = r;
          made.push_back(closing_report(ST_OK, slot));
        end else if (cmd == CMD_REMOVE) begin
          slot_used[slot] = 1'b0;
          made.push_back(closing_report(ST_OK, slot));
        end else begin
          // walk the higher slots; at most MaxResults-1 hits before the closer
          for (int i = int'(slot) + 1; i < SLOTS; i++) begin
            if (slot_used[i] && hits < MaxResults - 1 &&
                rects_touch(rect_mem[slot], rect_mem[i])) begin
              hit_rep        = '0;
              hit_rep.first  = slot;
              hit_rep.second = SlotW'(i);
              hit_rep.hit    = 1'b1;
              hit_rep.nf     = mask_says(kind_mem[slot].code, kind_mem[i].code) &
                               kind_mem[slot].handler;
              hit_rep.ns     = mask_says(kind_mem[i].code, kind_mem[slot].code) &
                               kind_mem[i].handler;
              made.push_back(hit_rep);
              hits++;
            end
          end
          made.push_back(closing_report(ST_OK, slot));
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
        made.push_back(closing_report(ST_OK, '0));
      end
      default: ;  // spare codes: ignored, no result
    endcase
  endtask

  // Sampling at the rising edge: result check first, then register write,
  // then the item taken at this edge. All values read are pre-edge.
  always @(posedge clk_i) begin
    pair_report_t due;
    pair_report_t made [$];
    if (rst_ni) begin
      if (result_strobe_o === 1'b1) begin
        if (reports_due.size() == 0) begin
          report_mismatch("unexpected result item", 16'd0, 16'd1);
        end else begin
          due = reports_due.pop_front();
          if (status_o !== due.status)
            report_mismatch("status", 16'(due.status), 16'(status_o));
          if (first_slot_o !== due.first)
            report_mismatch("first_slot", 16'(due.first), 16'(first_slot_o));
          if (second_slot_o !== due.second)
            report_mismatch("second_slot", 16'(due.second), 16'(second_slot_o));
          if (hit_o !== due.hit)
            report_mismatch("hit", 16'(due.hit), 16'(hit_o));
          if (notify_first_o !== due.nf)
            report_mismatch("notify_first", 16'(due.nf), 16'(notify_first_o));
          if (notify_second_o !== due.ns)
            report_mismatch("notify_second", 16'(due.ns), 16'(notify_second_o));
          if (last_o !== due.last)
            report_mismatch("last", 16'(due.last), 16'(last_o));
        end
      end
      if (cfg_we_i) mask_mem[cfg_index_i] = cfg_wdata_i;
      if (start_i && busy_o === 1'b0) begin
        made.delete();
        run_table_command(command_i, slot_i, {rect_h_i, rect_w_i, rect_y_i, rect_x_i},
                          {has_handler_i, kind_i}, made);
        if (typed_on) reports_due.push_back(typed_want);
        else foreach (made[j]) reports_due.push_back(made[j]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver. Everything changes at falling edges.
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the rising edge that takes the item.
  task automatic drive_item(input logic [2:0] cmd, input logic [SlotW-1:0] slot,
                            input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic [14:0] w, input logic [14:0] h,
                            input logic [KindW-1:0] kind, input logic handler,
                            input bit typed, input pair_report_t want);
    start_i       = 1'b1;
    command_i     = cmd;
    slot_i        = slot;
    rect_x_i      = x;
    rect_y_i      = y;
    rect_w_i      = w;
    rect_h_i      = h;
    kind_i        = kind;
    has_handler_i = handler;
    typed_on      = typed;
    typed_want    = want;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
  endtask

  // Drops start, waits for every owed result, then lets a walk finish anyway.
  task automatic settle_table();
    @(negedge clk_i);
    start_i = 1'b0;
    while (reports_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_mask(input logic [1:0] index, input logic [MaskW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = index;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic write_masks(input logic [MaskW-1:0] m0, input logic [MaskW-1:0] m1,
                             input logic [MaskW-1:0] m2, input logic [MaskW-1:0] m3);
    write_mask(REG_MASK_0, m0);
    write_mask(REG_MASK_1, m1);
    write_mask(REG_MASK_2, m2);
    write_mask(REG_MASK_3, m3);
  endtask

  function automatic script_row_t plan_row(input logic [2:0] cmd, input int slot,
                                           input int x, input int y, input int w, input int h,
                                           input int kind, input int handler, input int reps,
                                           input int typed, input pair_report_t want);
    script_row_t row;
    row.cmd     = cmd;
    row.slot    = SlotW'(slot);
    row.x       = 16'(x);
    row.y       = 16'(y);
    row.w       = 15'(w);
    row.h       = 15'(h);
    row.kind    = KindW'(kind);
    row.handler = (handler != 0);
    row.reps    = reps;
    row.typed   = (typed != 0);
    row.want    = want;
    return row;
  endfunction

  script_row_t script [$];
  int          idle_pct [4] = '{0, 52, 0, 34};

  initial begin
    int               r, done, tmp;
    int               live [$];
    logic [2:0]       cmd;
    logic [SlotW-1:0] slot;
    logic signed [15:0] x, y;
    logic [14:0]      w, h;
    logic [MaskW-1:0] m [4];

    // every input known from time zero
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    command_i     = CMD_CLEAR;
    slot_i        = '0;
    rect_x_i      = '0;
    rect_y_i      = '0;
    rect_w_i      = '0;
    rect_h_i      = '0;
    kind_i        = '0;
    has_handler_i = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_MASK_0;
    cfg_wdata_i   = '0;
    typed_on      = 1'b0;
    typed_want    = '0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Opening script: empty-target errors on a fresh table, extreme rectangles,
    // edge and corner contact, the spare codes, a full table and a check that
    // produces the largest burst of hits.
    script.push_back(plan_row(CMD_CHECK,  0, 0, 0, 0, 0, 0, 0, 1, 1,
                              closing_report(ST_EMPTY, 4'd0)));
    script.push_back(plan_row(CMD_UPDATE, 15, 1, 2, 3, 4, 0, 0, 1, 1,
                              closing_report(ST_EMPTY, 4'd15)));
    script.push_back(plan_row(CMD_REMOVE, 7, 0, 0, 0, 0, 0, 0, 1, 1,
                              closing_report(ST_EMPTY, 4'd7)));
    script.push_back(plan_row(CMD_CLEAR,  9, 0, 0, 0, 0, 0, 0, 1, 1,
                              closing_report(ST_OK, 4'd0)));
    script.push_back(plan_row(CMD_ADD, 0, -32768, -32768, 32767, 32767, 15, 1, 1, 1,
                              closing_report(ST_OK, 4'd0)));
    script.push_back(plan_row(CMD_ADD, 0, 32767, 32767, 0, 0, 0, 0, 1, 1,
                              closing_report(ST_OK, 4'd1)));
    // single point on the far corner of slot 0
    script.push_back(plan_row(CMD_ADD, 0, -1, -1, 0, 0, 5, 1, 1, 1,
                              closing_report(ST_OK, 4'd2)));
    script.push_back(plan_row(CMD_ADD, 0, 0, 0, 10, 10, 10, 1, 1, 1,
                              closing_report(ST_OK, 4'd3)));
    // shares the right edge of slot 3
    script.push_back(plan_row(CMD_ADD, 0, 10, 5, 3, 3, 3, 1, 1, 1,
                              closing_report(ST_OK, 4'd4)));
    script.push_back(plan_row(CMD_CHECK,  0, 0, 0, 0, 0, 0, 0, 1, 0, '0));
    script.push_back(plan_row(CMD_CHECK,  3, 0, 0, 0, 0, 0, 0, 1, 0, '0));
    script.push_back(plan_row(CMD_UPDATE, 1, -5, -5, 20, 20, 0, 0, 1, 1,
                              closing_report(ST_OK, 4'd1)));
    script.push_back(plan_row(CMD_CHECK,  0, 0, 0, 0, 0, 0, 0, 1, 0, '0));
    script.push_back(plan_row(CMD_CHECK,  1, 0, 0, 0, 0, 0, 0, 1, 0, '0));
    script.push_back(plan_row(CMD_REMOVE, 2, 0, 0, 0, 0, 0, 0, 1, 1,
                              closing_report(ST_OK, 4'd2)));
    script.push_back(plan_row(CMD_CHECK,  2, 0, 0, 0, 0, 0, 0, 1, 1,
                              closing_report(ST_EMPTY, 4'd2)));
    script.push_back(plan_row(CMD_SPARE_LO, 0, 0, 0, 0, 0, 0, 0, 1, 0, '0));
    script.push_back(plan_row(CMD_SPARE_HI, 15, -1, -1, 32767, 32767, 15, 1, 1, 0, '0));
    // freed slot 2 is the lowest free one again
    script.push_back(plan_row(CMD_ADD, 0, -3, -3, 6, 6, 12, 1, 1, 1,
                              closing_report(ST_OK, 4'd2)));
    // fill the rest of the table with one overlapping rectangle
    script.push_back(plan_row(CMD_ADD, 0, -10, -10, 40, 40, 9, 1, 11, 0, '0));
    script.push_back(plan_row(CMD_ADD, 0, 1, 1, 1, 1, 1, 1, 1, 1,
                              closing_report(ST_FULL, 4'd0)));
    // slot 0 now covers every other slot: fifteen hits before the closer
    script.push_back(plan_row(CMD_UPDATE, 0, -100, -100, 32767, 32767, 0, 0, 1, 1,
                              closing_report(ST_OK, 4'd0)));
    script.push_back(plan_row(CMD_CHECK,  0, 0, 0, 0, 0, 0, 0, 1, 0, '0));
    script.push_back(plan_row(CMD_CLEAR,  3, 0, 0, 0, 0, 0, 0, 1, 1,
                              closing_report(ST_OK, 4'd0)));
    script.push_back(plan_row(CMD_CHECK,  4, 0, 0, 0, 0, 0, 0, 1, 1,
                              closing_report(ST_EMPTY, 4'd4)));

    write_masks(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                64'hA5A5_5A5A_FFFF_0000, 64'h8000_0001_F0F0_0F0F);
    foreach (script[i]) begin
      repeat (script[i].reps) begin
        @(negedge clk_i);
        drive_item(script[i].cmd, script[i].slot, script[i].x, script[i].y,
                   script[i].w, script[i].h, script[i].kind, script[i].handler,
                   script[i].typed, script[i].want);
      end
    end

    // Random phases, each under a fresh mask setting: all ones, random,
    // all zeros, random. Idle pattern of the sender changes with the phase.
    for (int p = 0; p < 4; p++) begin
      settle_table();
      for (int k = 0; k < MaskRegs; k++) begin
        if (p == 0)      m[k] = '1;
        else if (p == 2) m[k] = '0;
        else             m[k] = {$urandom, $urandom};
      end
      write_masks(m[0], m[1], m[2], m[3]);

      done = 0;
      while (done < PHASE_ITEMS) begin
        @(negedge clk_i);
        if ($urandom_range(0, 99) < idle_pct[p]) begin
          // gap with junk on the fields; start low so none of it counts
          start_i       = 1'b0;
          command_i     = 3'($urandom);
          slot_i        = SlotW'($urandom);
          rect_x_i      = 16'($urandom);
          rect_y_i      = 16'($urandom);
          rect_w_i      = 15'($urandom);
          rect_h_i      = 15'($urandom);
          kind_i        = KindW'($urandom);
          has_handler_i = 1'($urandom);
          repeat ($urandom_range(1, SETTLE)) @(negedge clk_i);
        end
        if (p == 1 && done == PHASE_ITEMS / 2) begin
          // hold off until the block has delivered everything owed
          start_i = 1'b0;
          while (reports_due.size() != 0) @(negedge clk_i);
        end

        live.delete();
        for (int i = 0; i < SLOTS; i++) if (slot_used[i]) live.push_back(i);

        // mostly well-formed traffic on occupied slots, some misses and noise
        r = $urandom_range(0, 99);
        if (r < 28 || (live.size() < 2 && r < 60)) cmd = CMD_ADD;
        else if (r < 60) cmd = CMD_CHECK;
        else if (r < 74) cmd = CMD_UPDATE;
        else if (r < 94) cmd = CMD_REMOVE;
        else if (r < 97) cmd = CMD_CLEAR;
        else cmd = 3'($urandom_range(int'(CMD_SPARE_LO), int'(CMD_SPARE_HI)));

        if (live.size() != 0 && $urandom_range(0, 99) < 85)
          slot = SlotW'(live[$urandom_range(0, live.size() - 1)]);
        else
          slot = SlotW'($urandom_range(0, SLOTS - 1));

        if ($urandom_range(0, 99) < 80) begin
          // small rectangles round the origin, so that pairs often touch
          tmp = $urandom_range(0, 200);
          x   = 16'(tmp - 100);
          tmp = $urandom_range(0, 200);
          y   = 16'(tmp - 100);
          w   = 15'($urandom_range(0, 60));
          h   = 15'($urandom_range(0, 60));
        end else begin
          x = 16'($urandom);
          y = 16'($urandom);
          w = 15'($urandom_range(0, 32767));
          h = 15'($urandom_range(0, 32767));
        end

        drive_item(cmd, slot, x, y, w, h, KindW'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)), 1'b0, '0);
        if (cmd < CMD_SPARE_LO) done++;
      end
    end

    settle_table();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
